/* hdl/fdli_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdli_pkg
// Shared types, widths and helpers for the interpolating feedback delay line.
// ----------------------------------------------------------------------------
package fdli_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CH_W     = 3;
	localparam int DELAY_W  = 20;
	localparam int MAC_B_W  = 17;
	localparam int ACC_W    = SAMPLE_W + MAC_B_W;
	localparam int SUM_W    = SAMPLE_W + 2;

	localparam int FB_SHIFT = 15;
	localparam int FB_ROUND = 16384;

	// shared multiply-accumulate operations
	localparam logic MAC_OP_LOAD = 1'b0;
	localparam logic MAC_OP_ACC  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic en;
		logic op;
	} fdli_mac_ctl_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic rd_old;
		logic adv;
	} fdli_ring_ctl_t;

	function automatic sample_t sat16(input logic signed [SUM_W-1:0] v);
		sample_t r;
		if (v > SUM_W'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -SUM_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* hdl/fdli_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdli_mac
// Shared signed multiplier with a registered accumulator.
// ----------------------------------------------------------------------------
module fdli_mac import fdli_pkg::*; (
	input  wire                       clk,
	input  fdli_mac_ctl_t             ctl,
	input  sample_t                   a,
	input  wire signed [MAC_B_W-1:0]  b,
	input  wire signed [ACC_W-1:0]    bias,
	output logic signed [ACC_W-1:0]   acc_q
);

	logic signed [ACC_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.op)
				MAC_OP_LOAD: acc_q <= prod + bias;
				MAC_OP_ACC:  acc_q <= acc_q + prod + bias;
				default:     acc_q <= acc_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/fdli_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdli_ring
// Per-channel sample rings in one memory, with write pointers and tap
// address generation. Slots never written read back as zero.
// ----------------------------------------------------------------------------
module fdli_ring import fdli_pkg::*; #(
	parameter int CHANNELS = 2,
	parameter int CAPACITY = 4096,
	localparam int PW = $clog2(CAPACITY),
	localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fdli_ring_ctl_t      ctl,
	input  wire [CIW-1:0]       ch,
	input  wire [PW-1:0]        dly,
	input  sample_t             wr_data,
	output sample_t             rd_data
);

	localparam int DEPTH = CHANNELS * CAPACITY;
	localparam int AW = $clog2(DEPTH);
	localparam logic [PW:0]   CAP_W    = (PW+1)'(CAPACITY);
	localparam logic [PW-1:0] CAP_LAST = PW'(CAPACITY - 1);
	localparam logic [AW-1:0] CAP_A    = AW'(CAPACITY);

	sample_t mem [DEPTH];

	logic [PW-1:0]       wp_q [CHANNELS];
	logic [CHANNELS-1:0] wrapped_q;
	sample_t             rd_raw_q;
	logic                rd_ok_q;

	logic [PW-1:0] wp;
	logic          wrapped;
	logic [PW:0]   diff;
	logic [PW:0]   diff_w;
	logic [PW-1:0] i_new;
	logic [PW-1:0] i_old;
	logic [PW-1:0] rd_idx;
	logic [AW-1:0] base;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          rd_hit;

	assign wp      = wp_q[ch];
	assign wrapped = wrapped_q[ch];

	// newest entry minus integer delay, modulo ring size
	assign diff   = {1'b0, wp} - {1'b0, dly};
	assign diff_w = diff + CAP_W;
	assign i_new  = diff[PW] ? diff_w[PW-1:0] : diff[PW-1:0];
	assign i_old  = (i_new == '0) ? CAP_LAST : i_new - PW'(1);
	assign rd_idx = ctl.rd_old ? i_old : i_new;

	assign base  = AW'(ch) * CAP_A;
	assign waddr = base + AW'(wp);
	assign raddr = base + AW'(rd_idx);

	// before the first wrap only slots up to the pointer hold data
	assign rd_hit = wrapped || (rd_idx <= wp);

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_raw_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (ctl.rd) begin
			rd_ok_q <= rd_hit;
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i] <= '0;
			end
			wrapped_q <= '0;
		end else if (ctl.adv) begin
			if (wp == CAP_LAST) begin
				wp_q[ch]      <= '0;
				wrapped_q[ch] <= 1'b1;
			end else begin
				wp_q[ch] <= wp + PW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/feedback_delay_line_interp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_delay_line_interp
// Multichannel feedback delay with linear interpolation between two taps.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// s_       | in        | s_tvalid / s_tready  | s_tdata, s_tuser
// m_       | out       | m_tvalid / m_tready  | m_tdata
// cfg_     | in        | cfg_valid/cfg_ready  | cfg_data (wet_only)
//
// A word for a present channel passes through the feedback product, the ring
// write, two tap reads on the single memory port and two products on the one
// shared multiplier before ready returns. A word for a missing channel goes
// straight to the output step. No clearing pass after reset:
// slots not yet written read as zero. The result waits in the output
// register; the block stalls in its last step only while that is still full.
// ----------------------------------------------------------------------------
module feedback_delay_line_interp import fdli_pkg::*; #(
	parameter int CHANNELS  = 2,
	parameter int CAPACITY  = 4096,
	parameter int FRAC_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// channel[2:0], sample[18:3], delay_samples[38:19], feedback_gain[54:39]
	input  wire [55:0]  s_tdata,
	// silent[0]
	input  wire [0:0]   s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// out_channel[2:0], output_sample[18:3]
	output logic [23:0] m_tdata,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data
);

	localparam int PW  = $clog2(CAPACITY);
	localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FW  = (FRAC_BITS > 0) ? FRAC_BITS : 1;

	localparam logic [63:0] MAX_DELAY = 64'(CAPACITY - 2) << FRAC_BITS;
	localparam logic [63:0] FMASK     = 64'((1 << FRAC_BITS) - 1);
	localparam logic [CH_W:0] CH_LIM  = (CH_W+1)'(CHANNELS);
	localparam logic signed [MAC_B_W-1:0] ONE_B  = MAC_B_W'(1 << FRAC_BITS);
	localparam logic signed [ACC_W-1:0]   HALF_A = ACC_W'((1 << FRAC_BITS) / 2);
	localparam logic signed [ACC_W-1:0]   FBR_A  = ACC_W'(FB_ROUND);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FB   = 3'd1;
	localparam logic [2:0] ST_WR   = 3'd2;
	localparam logic [2:0] ST_RDN  = 3'd3;
	localparam logic [2:0] ST_RDO  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic [CH_W-1:0]     ch_q;
	logic                bad_q;
	sample_t             dry_q;
	sample_t             gain_q;
	logic [PW-1:0]       d_q;
	logic [FW-1:0]       f_q;
	logic                wet_only_q;
	logic                out_valid_q;
	logic [CH_W-1:0]     out_ch_q;
	sample_t             out_smp_q;
	sample_t             last_out_q [CHANNELS];

	logic [CH_W-1:0]     in_ch;
	sample_t             in_sample;
	logic [DELAY_W-1:0]  in_delay;
	sample_t             in_gain;
	logic [63:0]         dly64;
	logic [63:0]         dly_c;
	logic                accept;
	logic                out_free;
	logic [CIW-1:0]      ch_idx;

	fdli_mac_ctl_t               mac_ctl;
	sample_t                     mac_a;
	logic signed [MAC_B_W-1:0]   mac_b;
	logic signed [ACC_W-1:0]     mac_bias;
	logic signed [ACC_W-1:0]     acc_q;
	fdli_ring_ctl_t              ring_ctl;
	sample_t                     rd_data;

	logic signed [SUM_W-1:0]     fb_term;
	logic signed [SUM_W-1:0]     wet;
	logic signed [SUM_W-1:0]     y_sum;
	sample_t                     stored;
	sample_t                     y;

	assign in_ch     = s_tdata[2:0];
	assign in_sample = s_tdata[18:3];
	assign in_delay  = s_tdata[38:19];
	assign in_gain   = s_tdata[54:39];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign ch_idx   = ch_q[CIW-1:0];

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {5'b0, out_smp_q, out_ch_q};

	// clamp the delay to the usable ring length
	assign dly64 = 64'(in_delay);
	assign dly_c = (dly64 > MAX_DELAY) ? MAX_DELAY : dly64;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			wet_only_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= in_ch;
			dry_q  <= s_tuser[0] ? '0 : in_sample;
			gain_q <= in_gain;
			d_q    <= PW'(dly_c >> FRAC_BITS);
			f_q    <= FW'(dly_c & FMASK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bad_q   <= ({1'b0, in_ch} >= CH_LIM);
						state_q <= ({1'b0, in_ch} >= CH_LIM) ? ST_OUT : ST_FB;
					end
				end
				ST_FB:  state_q <= ST_WR;
				ST_WR:  state_q <= ST_RDN;
				ST_RDN: state_q <= ST_RDO;
				ST_RDO: state_q <= ST_ACC;
				ST_ACC: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared multiplier schedule: feedback product, then the two tap weights
	always_comb begin
		mac_ctl  = '{en: 1'b0, op: MAC_OP_LOAD};
		mac_a    = rd_data;
		mac_b    = ONE_B - signed'({{(MAC_B_W-FW){1'b0}}, f_q});
		mac_bias = '0;
		case (state_q)
			ST_FB: begin
				mac_ctl  = '{en: 1'b1, op: MAC_OP_LOAD};
				mac_a    = last_out_q[ch_idx];
				mac_b    = MAC_B_W'(gain_q);
				mac_bias = FBR_A;
			end
			ST_RDO: begin
				mac_ctl = '{en: 1'b1, op: MAC_OP_LOAD};
			end
			ST_ACC: begin
				mac_ctl  = '{en: 1'b1, op: MAC_OP_ACC};
				mac_b    = signed'({{(MAC_B_W-FW){1'b0}}, f_q});
				mac_bias = HALF_A;
			end
			default: begin
				mac_ctl = '{en: 1'b0, op: MAC_OP_LOAD};
			end
		endcase
	end

	fdli_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.a     (mac_a),
		.b     (mac_b),
		.bias  (mac_bias),
		.acc_q (acc_q)
	);

	assign fb_term = SUM_W'(acc_q >>> FB_SHIFT);
	assign stored  = sat16(SUM_W'(dry_q) + fb_term);
	assign wet     = SUM_W'(acc_q >>> FRAC_BITS);
	assign y_sum   = wet_only_q ? wet : SUM_W'(dry_q) + wet;
	assign y       = bad_q ? '0 : sat16(y_sum);

	always_comb begin
		ring_ctl.wr     = (state_q == ST_WR);
		ring_ctl.rd     = (state_q == ST_RDN) || (state_q == ST_RDO);
		ring_ctl.rd_old = (state_q == ST_RDO);
		ring_ctl.adv    = (state_q == ST_OUT) && out_free && !bad_q;
	end

	fdli_ring #(
		.CHANNELS (CHANNELS),
		.CAPACITY (CAPACITY)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.ch      (ch_idx),
		.dly     (d_q),
		.wr_data (stored),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_out_q[i] <= '0;
			end
		end else if (ring_ctl.adv) begin
			last_out_q[ch_idx] <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_ch_q  <= ch_q;
			out_smp_q <= y;
		end
	end

`ifndef SYNTHESIS
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_FB || state_q == ST_OUT))
		else $error("accepted word did not start its sequence");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready raised right after an accept");

	a_no_write_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_ctl.wr || ring_ctl.adv) |-> !bad_q)
		else $error("ring touched for a missing channel");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the final step");
`endif

endmodule
`default_nettype wire

/* test/feedback_delay_line_interp_tb.sv */
// ----------------------------------------------------------------------------
// feedback_delay_line_interp_tb
// Streams per-channel samples with random delays and feedback gains through
// the delay line. A local model of the rings, write positions and last
// outputs predicts every output word, and the monitor checks each one in order.
// Both sides idle at random. The wet_only register is toggled between phases.
// ----------------------------------------------------------------------------
module feedback_delay_line_interp_tb import fdli_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS  = 2;
	localparam int CAPACITY  = 4096;
	localparam int FRAC_BITS = 8;
	localparam int unsigned DELAY_CAP = (CAPACITY - 2) << FRAC_BITS;
	localparam int unsigned DELAY_TOP = 1048319;
	localparam longint ONE  = 64'sd1 << FRAC_BITS;
	localparam longint HALF = (FRAC_BITS > 0) ? (ONE >>> 1) : 64'sd0;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [CH_W-1:0]    channel;
		logic               silent;
		sample_t            sample;
		logic [DELAY_W-1:0] delay;
		sample_t            gain;
	} in_word_t;

	typedef struct {
		logic [CH_W-1:0] channel;
		sample_t         value;
	} out_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	// channel[2:0], sample[18:3], delay_samples[38:19], feedback_gain[54:39]
	logic [55:0] s_tdata = '0;
	// silent[0]
	logic [0:0]  s_tuser = '0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	// out_channel[2:0], output_sample[18:3]
	wire  [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic        cfg_data = 1'b0;

	// model of the block's state
	sample_t     echo_ring [CHANNELS*CAPACITY];
	int unsigned echo_wp [CHANNELS];
	sample_t     echo_last [CHANNELS];
	bit          model_wet_only = 1'b0;

	in_word_t    src_samples [$];
	out_word_t   due_samples [$];

	int queued_cnt = 0;
	int accepted_cnt = 0;
	int results_cnt = 0;
	int cfg_writes = 0;
	int errors = 0;
	int cycles = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int src_gap = 0;
	int sink_wait = 0;
	bit s_taken = 1'b0;
	bit hold_go = 1'b0;
	bit hold_used = 1'b0;

	feedback_delay_line_interp #(
		.CHANNELS (CHANNELS),
		.CAPACITY (CAPACITY),
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic sample_t clip16(longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// advance the model by one word and return the output it produces
	function automatic out_word_t predict_delay_out(in_word_t w);
		out_word_t   r;
		longint      dry, fb, wet, f, acc;
		int unsigned base, wp, dl, d, i_new, i_old;
		sample_t     y;
		r.channel = w.channel;
		r.value = '0;
		if (w.channel >= CHANNELS) begin
			return r;
		end
		base = w.channel * CAPACITY;
		wp = echo_wp[w.channel];
		dry = w.silent ? 64'sd0 : longint'(w.sample);
		acc = longint'(echo_last[w.channel]) * longint'(w.gain) + 64'sd16384;
		fb = acc >>> 15;
		echo_ring[base + wp] = clip16(dry + fb);
		dl = w.delay;
		if (dl > DELAY_CAP) begin
			dl = DELAY_CAP;
		end
		d = dl >> FRAC_BITS;
		f = longint'(dl & ((1 << FRAC_BITS) - 1));
		i_new = (wp + CAPACITY - d) % CAPACITY;
		i_old = (wp + 2 * CAPACITY - d - 1) % CAPACITY;
		acc = longint'(echo_ring[base + i_new]) * (ONE - f)
			+ longint'(echo_ring[base + i_old]) * f + HALF;
		wet = acc >>> FRAC_BITS;
		y = clip16(model_wet_only ? wet : dry + wet);
		echo_last[w.channel] = y;
		echo_wp[w.channel] = (wp + 1) % CAPACITY;
		r.value = y;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %0s at cycle %0d: got %0d, want %0d", what, cycles, got, want);
		errors++;
	endtask

	task automatic queue_word(int ch, bit silent, int smp, int unsigned dl, int gain);
		in_word_t w;
		w.channel = ch[CH_W-1:0];
		w.silent = silent;
		w.sample = smp[15:0];
		w.delay = dl[DELAY_W-1:0];
		w.gain = gain[15:0];
		src_samples.insert(src_samples.size(), w);
		queued_cnt++;
	endtask

	// mostly short delays so the taps land on written slots, some long and clamped
	task automatic queue_random(int n);
		int          ch, smp, gain, pick;
		int unsigned dl;
		bit          silent;
		repeat (n) begin
			ch = ($urandom_range(0, 99) < 85) ? $urandom_range(0, CHANNELS - 1)
				: $urandom_range(CHANNELS, 7);
			silent = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				smp = 32767;
			end else if (pick == 1) begin
				smp = -32768;
			end else begin
				smp = $urandom_range(0, 65535);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				gain = -32768;
			end else if (pick < 8) begin
				gain = ($urandom_range(0, 1) != 0) ? 32767 : -32767;
			end else begin
				gain = $urandom_range(0, 65534) - 32767;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				dl = $urandom_range(0, 24 << FRAC_BITS);
			end else if (pick < 80) begin
				dl = $urandom_range(0, 1200 << FRAC_BITS);
			end else if (pick < 90) begin
				dl = $urandom_range(DELAY_CAP, DELAY_TOP);
			end else begin
				dl = $urandom_range(0, DELAY_TOP);
			end
			queue_word(ch, silent, smp, dl, gain);
		end
	endtask

	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || results_cnt < accepted_cnt) begin
			@(negedge clk);
		end
	endtask

	task automatic write_wet_only(bit v);
		int n;
		n = cfg_writes;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		while (cfg_writes == n) begin
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// sender: hold the word until taken, then idle or launch the next one
	always @(negedge clk) begin : drive_in
		in_word_t w;
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (src_samples.size() != 0) begin
				w = src_samples.pop_front();
				s_tdata <= {1'b0, w.gain, w.delay, w.sample, w.channel};
				s_tuser <= w.silent;
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 99) < src_idle_pct) begin
					src_gap <= $urandom_range(1, 15);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts plus one long hold-off
	always @(negedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			sink_wait <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			sink_wait <= $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// check results first, then predict for the word taken at this edge
	always @(posedge clk) begin : watch
		in_word_t  got_in;
		out_word_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			s_taken <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready) begin
				model_wet_only <= cfg_data;
				cfg_writes <= cfg_writes + 1;
			end
			if (m_tvalid && m_tready) begin
				results_cnt <= results_cnt + 1;
				if (due_samples.size() == 0) begin
					report_mismatch("unexpected word, channel", m_tdata[2:0], -1);
				end else begin
					want = due_samples.pop_front();
					if (m_tdata[2:0] !== want.channel) begin
						report_mismatch("out_channel", m_tdata[2:0], want.channel);
					end
					if (m_tdata[18:3] !== want.value) begin
						report_mismatch("output_sample", $signed(m_tdata[18:3]), want.value);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				got_in.channel = s_tdata[2:0];
				got_in.sample = s_tdata[18:3];
				got_in.delay = s_tdata[38:19];
				got_in.gain = s_tdata[54:39];
				got_in.silent = s_tuser[0];
				due_samples.insert(due_samples.size(), predict_delay_out(got_in));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < CHANNELS * CAPACITY; i++) begin
			echo_ring[i] = '0;
		end
		for (int c = 0; c < CHANNELS; c++) begin
			echo_wp[c] = 0;
			echo_last[c] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, zero delay, clamped delays, missing channels, full-scale gains
		queue_word(0, 0, 32767, 0, 0);
		queue_word(0, 0, -32768, 0, 32767);
		queue_word(1, 0, 1000, 1 << FRAC_BITS, -32768);
		queue_word(1, 1, 12345, (1 << FRAC_BITS) | 128, 16384);
		queue_word(0, 0, 16384, (2 << FRAC_BITS) | 255, -32767);
		queue_word(0, 0, -1, DELAY_CAP, 32767);
		queue_word(1, 0, 555, DELAY_CAP + 1, 100);
		queue_word(0, 0, 7, DELAY_TOP, -100);
		queue_word(2, 0, 32767, 5, 32767);
		queue_word(7, 1, -32768, DELAY_TOP, -32768);
		queue_word(0, 0, 32767, 3 << FRAC_BITS, 32767);
		queue_word(1, 0, -32768, 0, -32768);
		queue_word(0, 0, 20000, 255, 32767);
		queue_word(1, 0, -20000, 4 << FRAC_BITS, 32767);
		queue_word(0, 1, 0, 1, -32768);
		queue_word(1, 0, 32767, DELAY_TOP, 0);
		wait_drained();

		write_wet_only(1'b1);
		src_idle_pct = 20;
		sink_idle_pct = 30;
		hold_go = 1'b1;
		queue_random(450);
		wait_drained();

		write_wet_only(1'b0);
		src_idle_pct = 15;
		sink_idle_pct = 45;
		queue_random(450);
		wait_drained();

		write_wet_only(1'b1);
		src_idle_pct = 40;
		sink_idle_pct = 10;
		queue_random(450);
		wait_drained();

		// closing stretch at full rate
		write_wet_only(1'b0);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		queue_random(450);
		wait_drained();

		repeat (30) @(posedge clk);
		if (due_samples.size() != 0) begin
			report_mismatch("words never produced", 0, due_samples.size());
		end
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/fdli_pkg.sv
hdl/fdli_mac.sv
hdl/fdli_ring.sv
hdl/feedback_delay_line_interp.sv
test/feedback_delay_line_interp_tb.sv
